FILE: rtl/pjd_pkg.sv
`default_nettype none

package pjd_pkg;

	localparam int JOBS_DEFAULT = 4;

	localparam logic [7:0] STAGGER_RESET = 8'd5;
	localparam logic [7:0] MARGIN_RESET = 8'd5;

	localparam logic [0:0] CFG_STAGGER = 1'b0;
	localparam logic [0:0] CFG_MARGIN = 1'b1;

	localparam logic [2:0] CMD_REGISTER = 3'd0;
	localparam logic [2:0] CMD_SET_PERIOD = 3'd1;
	localparam logic [2:0] CMD_REQUEST = 3'd2;
	localparam logic [2:0] CMD_SET_ONLINE = 3'd3;
	localparam logic [2:0] CMD_TICK = 3'd4;
	localparam logic [2:0] CMD_QUERY = 3'd5;

	typedef struct packed {
		logic [2:0] cmd;
		logic [1:0] job_id;
		logic [19:0] period;
		logic handler_present;
		logic online_flag;
		logic [15:0] elapsed;
		logic [31:0] now;
	} pjd_item_t;

	typedef struct packed {
		logic ran;
		logic [1:0] ran_job;
		logic ran_call;
		logic [2:0] pending_jobs;
		logic [31:0] job_last_run;
	} pjd_result_t;

	typedef struct packed {
		logic handler;
		logic [31:0] last_time;
		logic [20:0] countdown;
		logic [19:0] period;
	} pjd_entry_t;

endpackage

`default_nettype wire

FILE: rtl/pjd_core.sv
`default_nettype none

module pjd_core import pjd_pkg::*; #(
	parameter int JOBS = JOBS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire pjd_item_t item,
	input wire logic [7:0] stagger,
	input wire logic [7:0] margin,
	input wire logic out_free,
	output logic ready,
	output logic res_valid,
	output pjd_result_t res
);

	localparam int IDX_W = (JOBS > 1) ? $clog2(JOBS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOBS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_EVAL,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t state_q;
	pjd_item_t item_q;
	logic [IDX_W-1:0] walk_q;
	logic found_q;
	logic online_q;
	logic [2:0] count_q;
	logic [JOBS-1:0] pending_q;
	logic [JOBS-1:0] registered_q;
	logic [JOBS-1:0] written_q;
	logic ran_q;
	logic [1:0] ran_job_q;
	logic ran_call_q;
	logic [31:0] last_q;
	logic res_valid_q;

	pjd_entry_t mem [JOBS];
	pjd_entry_t rd_s1;

	logic [IDX_W-1:0] id_addr;
	logic id_valid;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] ev_addr;
	pjd_entry_t ent;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	pjd_entry_t wr_data;

	logic [9:0] stag_prod;
	logic [21:0] reg_sum;
	logic [20:0] reg_cd;
	logic [31:0] since;
	logic [20:0] sp_cd;

	logic reg_w;
	logic pend_w;
	logic tk_active;
	logic tk_expired;
	logic tk_pend;
	logic tk_dispatch;
	logic [20:0] tk_cd;
	logic [31:0] tk_last;

	assign id_addr = IDX_W'(item_q.job_id);
	assign id_valid = ({4'b0, item_q.job_id} < 6'(JOBS));
	assign ev_addr = (state_q == ST_WALK_EV) ? walk_q : id_addr;
	assign ent = written_q[ev_addr] ? rd_s1 : '0;

	always_comb begin
		rd_addr = id_addr;
		if (state_q == ST_WALK_RD) begin
			rd_addr = walk_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		stag_prod = {8'b0, item_q.job_id} * {2'b0, stagger};
		reg_sum = {2'b0, item_q.period} + {12'b0, stag_prod};
		if (item_q.period == '0) begin
			reg_cd = '0;
		end else if (reg_sum[21]) begin
			reg_cd = '1;
		end else begin
			reg_cd = reg_sum[20:0];
		end

		since = item_q.now - ent.last_time;
		if (item_q.period == '0) begin
			sp_cd = '0;
		end else if (since >= {12'b0, item_q.period}) begin
			sp_cd = {13'b0, margin};
		end else begin
			sp_cd = 21'({12'b0, item_q.period} - since);
		end

		reg_w = registered_q[walk_q];
		pend_w = pending_q[walk_q];
		tk_active = reg_w && (ent.period != '0);
		tk_expired = (ent.countdown <= {5'b0, item_q.elapsed});
		tk_cd = ent.countdown;
		tk_last = ent.last_time;
		tk_pend = pend_w;
		if (tk_active) begin
			if (tk_expired) begin
				tk_cd = '0;
				tk_pend = 1'b1;
			end else begin
				tk_cd = ent.countdown - {5'b0, item_q.elapsed};
			end
		end
		tk_dispatch = online_q && !found_q && reg_w && tk_pend;
		if (tk_dispatch) begin
			tk_cd = {1'b0, ent.period};
			tk_last = item_q.now;
			tk_pend = 1'b0;
		end

		wr_en = 1'b0;
		wr_addr = id_addr;
		wr_data = ent;
		unique case (state_q)
			ST_START: begin
				if (item_q.cmd == CMD_REGISTER && id_valid) begin
					wr_en = 1'b1;
					wr_data = '{handler: item_q.handler_present, last_time: '0,
						countdown: reg_cd, period: item_q.period};
				end
			end
			ST_EVAL: begin
				wr_en = 1'b1;
				if (item_q.cmd == CMD_SET_PERIOD) begin
					wr_data.period = item_q.period;
					wr_data.countdown = sp_cd;
				end else begin
					wr_data.countdown = {1'b0, ent.period};
				end
			end
			ST_WALK_EV: begin
				wr_addr = walk_q;
				if (item_q.cmd == CMD_TICK) begin
					wr_en = 1'b1;
					wr_data.countdown = tk_cd;
					wr_data.last_time = tk_last;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q <= '0;
			found_q <= 1'b0;
			online_q <= 1'b0;
			count_q <= '0;
			pending_q <= '0;
			registered_q <= '0;
			written_q <= '0;
			ran_q <= 1'b0;
			ran_job_q <= '0;
			ran_call_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= item;
						ran_q <= 1'b0;
						ran_job_q <= '0;
						ran_call_q <= 1'b0;
						found_q <= 1'b0;
						walk_q <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_FIN;
					unique case (item_q.cmd)
						CMD_REGISTER: begin
							if (id_valid) begin
								written_q[id_addr] <= 1'b1;
								registered_q[id_addr] <= 1'b1;
								pending_q[id_addr] <= 1'b0;
								count_q <= count_q - 3'(pending_q[id_addr]);
							end
						end
						CMD_SET_PERIOD: begin
							if (id_valid) begin
								state_q <= ST_EVAL;
							end
						end
						CMD_REQUEST: begin
							if (id_valid && registered_q[id_addr]) begin
								state_q <= ST_EVAL;
							end
						end
						CMD_SET_ONLINE: begin
							if (item_q.online_flag != online_q) begin
								online_q <= item_q.online_flag;
								if (item_q.online_flag) begin
									state_q <= ST_WALK_RD;
								end
							end
						end
						CMD_TICK: begin
							state_q <= ST_WALK_RD;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_EVAL: begin
					written_q[id_addr] <= 1'b1;
					if (item_q.cmd == CMD_REQUEST) begin
						pending_q[id_addr] <= 1'b1;
						count_q <= count_q + 3'(!pending_q[id_addr]);
					end
					state_q <= ST_FIN;
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_EV;
				end
				ST_WALK_EV: begin
					if (item_q.cmd == CMD_TICK) begin
						written_q[walk_q] <= 1'b1;
						pending_q[walk_q] <= tk_pend;
						count_q <= count_q + 3'(tk_pend && !pend_w)
							- 3'(pend_w && !tk_pend);
						if (tk_dispatch) begin
							found_q <= 1'b1;
							ran_q <= 1'b1;
							ran_job_q <= 2'(walk_q);
							ran_call_q <= ent.handler;
						end
					end else if (reg_w && ent.period != '0 && !pend_w) begin
						pending_q[walk_q] <= 1'b1;
						count_q <= count_q + 3'd1;
					end
					if (walk_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						walk_q <= walk_q + 1'b1;
						state_q <= ST_WALK_RD;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						last_q <= id_valid ? ent.last_time : '0;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = '{ran: ran_q, ran_job: ran_job_q, ran_call: ran_call_q,
		pending_jobs: count_q, job_last_run: last_q};

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> count_q == 3'($countones(pending_q)))
		else $error("pending count differs from pending bits");

	a_pending_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~registered_q) == '0)
		else $error("pending bit set on an unregistered job");

	a_ran_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ran |-> item_q.cmd == CMD_TICK && online_q)
		else $error("dispatch reported outside an online tick");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("table written while idle");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == ST_IDLE && $past(state_q == ST_OUT))
		else $error("result issued outside the output step");

endmodule

`default_nettype wire

FILE: rtl/periodic_job_dispatcher.sv
// An item goes from acceptance to its result word through the start, finish and output steps,
// plus an evaluate step for a period change or a request and a walk over every job entry for a
// tick and for going online, reading each entry through the single job table memory and, for a
// tick, writing it back. A new item is taken once the sequencer is idle; the output step waits
// while the output register is full, so items never overlap. Reset is asynchronous
// and leaves every job unregistered, the block offline and both timing registers at 5 seconds.
`default_nettype none

module periodic_job_dispatcher import pjd_pkg::*; #(
	parameter int JOBS = JOBS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// job_id, period, handler_present, online_flag, elapsed, now
	input wire logic [71:0] s_tdata,
	// cmd
	input wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// ran, ran_job, ran_call, pending_jobs, job_last_run, one zero bit
	output logic [39:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [7:0] cfg_data
);

	logic [7:0] stagger_q;
	logic [7:0] margin_q;
	logic m_tvalid_q;
	logic [39:0] m_tdata_q;
	pjd_item_t item;
	logic core_ready;
	logic res_valid;
	pjd_result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stagger_q <= STAGGER_RESET;
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STAGGER: stagger_q <= cfg_data;
				CFG_MARGIN: margin_q <= cfg_data;
				default: stagger_q <= stagger_q;
			endcase
		end
	end

	assign item = '{cmd: s_tuser, job_id: s_tdata[1:0], period: s_tdata[21:2],
		handler_present: s_tdata[22], online_flag: s_tdata[23],
		elapsed: s_tdata[39:24], now: s_tdata[71:40]};

	assign s_tready = core_ready;

	pjd_core #(
		.JOBS(JOBS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(s_tvalid && core_ready),
		.item(item),
		.stagger(stagger_q),
		.margin(margin_q),
		.out_free(!m_tvalid_q || m_tready),
		.ready(core_ready),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= {1'b0, res.job_last_run, res.pending_jobs, res.ran_call,
				res.ran_job, res.ran};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

FILE: sim/periodic_job_dispatcher_tb.sv
`timescale 1ns / 100ps

module periodic_job_dispatcher_tb import pjd_pkg::*; ();

	localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 130;
	localparam int N_DIRECTED = 25;

	typedef struct {
		logic [2:0] cmd;
		logic [1:0] id;
		logic [19:0] period;
		logic hnd;
		logic onl;
		logic [15:0] elapsed;
		logic [31:0] now;
		bit typed;
		logic [2:0] pend;
		logic [31:0] last;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	logic [19:0] job_period [JOBS_DEFAULT];
	logic [20:0] job_count [JOBS_DEFAULT];
	bit job_pend [JOBS_DEFAULT];
	bit job_enrolled [JOBS_DEFAULT];
	bit job_has_cb [JOBS_DEFAULT];
	logic [31:0] job_last [JOBS_DEFAULT];
	bit online_st;
	logic [7:0] stagger_cfg;
	logic [7:0] margin_cfg;

	pjd_result_t expected_q [$];
	int mismatches = 0;
	int stall_left = 0;
	bit idle_en = 1'b1;
	logic [31:0] wall_sec = 32'd0;

	// Rows with typed expectations never dispatch, so ran, ran_job and ran_call are zero.
	// cmd, job, period, handler, online, elapsed, now, typed, pending, last run
	step_row_t directed_rows [N_DIRECTED] = '{
		'{CMD_QUERY, 2'd0, 20'd0, 1'b0, 1'b0, 16'd0, 32'd0, 1'b1, 3'd0, 32'd0},
		'{CMD_TICK, 2'd0, 20'd0, 1'b0, 1'b0, 16'hFFFF, 32'd0, 1'b1, 3'd0, 32'd0},
		'{CMD_SET_PERIOD, 2'd1, 20'd7, 1'b0, 1'b0, 16'd0, 32'd20, 1'b1, 3'd0, 32'd0},
		'{CMD_REQUEST, 2'd1, 20'd0, 1'b0, 1'b0, 16'd0, 32'd21, 1'b1, 3'd0, 32'd0},
		'{CMD_REGISTER, 2'd0, 20'd10, 1'b1, 1'b0, 16'd0, 32'd22, 1'b1, 3'd0, 32'd0},
		'{CMD_REGISTER, 2'd3, 20'hFFFFF, 1'b0, 1'b0, 16'd0, 32'd23, 1'b1, 3'd0, 32'd0},
		'{CMD_REGISTER, 2'd1, 20'd0, 1'b1, 1'b0, 16'd0, 32'd24, 1'b1, 3'd0, 32'd0},
		'{CMD_REGISTER, 2'd2, 20'd3, 1'b1, 1'b0, 16'd0, 32'd25, 1'b1, 3'd0, 32'd0},
		'{CMD_REQUEST, 2'd1, 20'd0, 1'b0, 1'b0, 16'd0, 32'd26, 1'b1, 3'd1, 32'd0},
		'{CMD_SET_ONLINE, 2'd0, 20'd0, 1'b0, 1'b1, 16'd0, 32'd27, 1'b1, 3'd4, 32'd0},
		'{CMD_SET_ONLINE, 2'd2, 20'd0, 1'b0, 1'b1, 16'd0, 32'd28, 1'b1, 3'd4, 32'd0},
		'{CMD_TICK, 2'd0, 20'd0, 1'b0, 1'b0, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 3'd0, 32'd0},
		'{CMD_TICK, 2'd1, 20'd0, 1'b0, 1'b0, 16'd0, 32'd1, 1'b0, 3'd0, 32'd0},
		'{CMD_TICK, 2'd2, 20'd0, 1'b0, 1'b0, 16'd0, 32'd2, 1'b0, 3'd0, 32'd0},
		'{CMD_TICK, 2'd3, 20'd0, 1'b0, 1'b0, 16'd1, 32'd3, 1'b0, 3'd0, 32'd0},
		'{CMD_SET_PERIOD, 2'd0, 20'd5, 1'b0, 1'b0, 16'd0, 32'd2, 1'b0, 3'd0, 32'd0},
		'{CMD_SET_PERIOD, 2'd0, 20'd1, 1'b0, 1'b0, 16'd0, 32'd40, 1'b0, 3'd0, 32'd0},
		'{CMD_SET_PERIOD, 2'd2, 20'd0, 1'b0, 1'b0, 16'd0, 32'd0, 1'b0, 3'd0, 32'd0},
		'{CMD_SET_PERIOD, 2'd2, 20'd8, 1'b0, 1'b0, 16'd0, 32'd0, 1'b0, 3'd0, 32'd0},
		'{CMD_SET_ONLINE, 2'd3, 20'd0, 1'b0, 1'b0, 16'd0, 32'd45, 1'b0, 3'd0, 32'd0},
		'{CMD_TICK, 2'd0, 20'd0, 1'b0, 1'b0, 16'hFFFF, 32'd50, 1'b0, 3'd0, 32'd0},
		'{CMD_REGISTER, 2'd2, 20'd4, 1'b0, 1'b0, 16'd0, 32'd51, 1'b0, 3'd0, 32'd0},
		'{CMD_QUERY, 2'd3, 20'd0, 1'b0, 1'b0, 16'd0, 32'd52, 1'b0, 3'd0, 32'd0},
		'{CMD_UNDEF_LO, 2'd0, 20'hFFFFF, 1'b1, 1'b1, 16'hFFFF, 32'd53, 1'b0, 3'd0, 32'd0},
		'{CMD_UNDEF_HI, 2'd3, 20'd0, 1'b1, 1'b1, 16'd0, 32'd54, 1'b0, 3'd0, 32'd0}
	};

	periodic_job_dispatcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("periodic_job_dispatcher regression: fail");
		$finish;
	end

	function automatic pjd_result_t dispatch_predict(pjd_item_t it);
		pjd_result_t r;
		logic [31:0] span;
		logic [31:0] sum;
		int n;
		bit dispatched;
		r = '0;
		dispatched = 1'b0;
		case (it.cmd)
		CMD_REGISTER: begin
			sum = 32'd0;
			if (it.period != 20'd0) begin
				sum = 32'(it.period) + 32'(it.job_id) * 32'(stagger_cfg);
				if (sum > 32'h1F_FFFF)
					sum = 32'h1F_FFFF;
			end
			job_period[it.job_id] = it.period;
			job_count[it.job_id] = sum[20:0];
			job_has_cb[it.job_id] = it.handler_present;
			job_pend[it.job_id] = 1'b0;
			job_enrolled[it.job_id] = 1'b1;
			job_last[it.job_id] = 32'd0;
		end
		CMD_SET_PERIOD: begin
			job_period[it.job_id] = it.period;
			if (it.period == 20'd0) begin
				job_count[it.job_id] = 21'd0;
			end else begin
				span = it.now - job_last[it.job_id];
				if (span >= 32'(it.period))
					job_count[it.job_id] = 21'(margin_cfg);
				else
					job_count[it.job_id] = 21'(32'(it.period) - span);
			end
		end
		CMD_REQUEST: begin
			if (job_enrolled[it.job_id]) begin
				job_pend[it.job_id] = 1'b1;
				job_count[it.job_id] = 21'(job_period[it.job_id]);
			end
		end
		CMD_SET_ONLINE: begin
			if (it.online_flag != online_st) begin
				online_st = it.online_flag;
				if (it.online_flag) begin
					for (int i = 0; i < JOBS_DEFAULT; i++)
						if (job_enrolled[i] && job_period[i] != 20'd0)
							job_pend[i] = 1'b1;
				end
			end
		end
		CMD_TICK: begin
			for (int i = 0; i < JOBS_DEFAULT; i++) begin
				if (!job_enrolled[i] || job_period[i] == 20'd0)
					continue;
				if (job_count[i] > 21'(it.elapsed)) begin
					job_count[i] = job_count[i] - 21'(it.elapsed);
				end else begin
					job_count[i] = 21'd0;
					job_pend[i] = 1'b1;
				end
			end
			if (online_st) begin
				for (int i = 0; i < JOBS_DEFAULT; i++) begin
					if (!dispatched && job_enrolled[i] && job_pend[i]) begin
						dispatched = 1'b1;
						job_pend[i] = 1'b0;
						job_count[i] = 21'(job_period[i]);
						job_last[i] = it.now;
						r.ran = 1'b1;
						r.ran_job = 2'(i);
						r.ran_call = job_has_cb[i];
					end
				end
			end
		end
		default: begin
		end
		endcase
		n = 0;
		for (int i = 0; i < JOBS_DEFAULT; i++)
			if (job_pend[i])
				n++;
		r.pending_jobs = 3'(n);
		r.job_last_run = job_last[it.job_id];
		return r;
	endfunction

	function automatic logic [19:0] random_period(logic [19:0] noise);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 20'd0;
		if (pick == 1)
			return noise;
		return 20'($urandom_range(1, 25));
	endfunction

	function automatic pjd_item_t random_item();
		pjd_item_t it;
		logic [95:0] noise;
		int sel;
		noise = {$urandom, $urandom, $urandom};
		it = noise[74:0];
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 19) != 0)
			it.now = wall_sec;
		if (sel < 40) begin
			it.cmd = CMD_TICK;
			if ($urandom_range(0, 99) < 85)
				it.elapsed = 16'($urandom_range(0, 12));
			wall_sec = wall_sec + 32'(it.elapsed);
			if ($urandom_range(0, 19) != 0)
				it.now = wall_sec;
		end else if (sel < 55) begin
			it.cmd = CMD_REGISTER;
			it.period = random_period(it.period);
		end else if (sel < 67) begin
			it.cmd = CMD_SET_PERIOD;
			it.period = random_period(it.period);
			if ($urandom_range(0, 19) != 0)
				it.now = wall_sec + 32'($urandom_range(0, 40));
		end else if (sel < 80) begin
			it.cmd = CMD_REQUEST;
		end else if (sel < 87) begin
			it.cmd = CMD_SET_ONLINE;
		end else if (sel < 97) begin
			it.cmd = CMD_QUERY;
		end else begin
			it.cmd = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
		end
		return it;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic put_item(pjd_item_t it, bit typed, pjd_result_t typed_res);
		pjd_result_t want;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {it.now, it.elapsed, it.online_flag, it.handler_present, it.period, it.job_id};
		do @(posedge clk); while (!s_tready);
		want = dispatch_predict(it);
		expected_q.push_back(typed ? typed_res : want);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_timing(logic [7:0] stagger, logic [7:0] margin);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_STAGGER;
		cfg_data <= stagger;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MARGIN;
		cfg_data <= margin;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		stagger_cfg = stagger;
		margin_cfg = margin;
	endtask

	always @(posedge clk) begin
		pjd_result_t got;
		pjd_result_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[2:1], m_tdata[3], m_tdata[6:4], m_tdata[38:7]};
			if (expected_q.size() == 0) begin
				$error("unexpected result word: %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("ran", 32'(want.ran), 32'(got.ran));
				check_field("ran_job", 32'(want.ran_job), 32'(got.ran_job));
				check_field("ran_call", 32'(want.ran_call), 32'(got.ran_call));
				check_field("pending_jobs", 32'(want.pending_jobs), 32'(got.pending_jobs));
				check_field("job_last_run", want.job_last_run, got.job_last_run);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		step_row_t row;
		pjd_item_t it;
		pjd_result_t typed_res;
		logic [7:0] phase_stagger [PHASES - 1];
		logic [7:0] phase_margin [PHASES - 1];
		phase_stagger = '{8'd0, 8'd255, 8'd255, 8'd0};
		phase_margin = '{8'd0, 8'd255, 8'd1, 8'd255};
		for (int i = 0; i < JOBS_DEFAULT; i++) begin
			job_period[i] = '0;
			job_count[i] = '0;
			job_pend[i] = 1'b0;
			job_enrolled[i] = 1'b0;
			job_has_cb[i] = 1'b0;
			job_last[i] = '0;
		end
		online_st = 1'b0;
		stagger_cfg = STAGGER_RESET;
		margin_cfg = MARGIN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int k = 0; k < N_DIRECTED; k++) begin
			row = directed_rows[k];
			it.cmd = row.cmd;
			it.job_id = row.id;
			it.period = row.period;
			it.handler_present = row.hnd;
			it.online_flag = row.onl;
			it.elapsed = row.elapsed;
			it.now = row.now;
			typed_res = '0;
			typed_res.pending_jobs = row.pend;
			typed_res.job_last_run = row.last;
			put_item(it, row.typed, typed_res);
		end
		wall_sec = 32'd60;

		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p < PHASES - 1)
				set_timing(phase_stagger[p], phase_margin[p]);
			else
				set_timing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			idle_en = (p != PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++)
				put_item(random_item(), 1'b0, '0);
		end

		settle();
		if (mismatches == 0) begin
			$display("periodic_job_dispatcher regression: pass");
		end else begin
			$display("periodic_job_dispatcher regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pjd_pkg.sv
rtl/pjd_core.sv
rtl/periodic_job_dispatcher.sv
sim/periodic_job_dispatcher_tb.sv
